// File: src/assert_macros.svh
// Assertion macros shared by the checker modules of the ALU block.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define CHK_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ALU port check failed");

// Condition that must hold at every rising clock edge outside reset.
`define CHK_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("ALU port check failed");

`endif

// File: src/z80alu_pkg.sv
// Package for the Z80 ALU: operation codes, flag bit positions, result struct
// and the parity helper. Depends on nothing.
package z80alu_pkg;

  // Operation codes carried on the mode port.
  localparam logic [4:0] OP_ADD   = 5'd0;
  localparam logic [4:0] OP_ADC   = 5'd1;
  localparam logic [4:0] OP_SUB   = 5'd2;
  localparam logic [4:0] OP_SBC   = 5'd3;
  localparam logic [4:0] OP_AND   = 5'd4;
  localparam logic [4:0] OP_XOR   = 5'd5;
  localparam logic [4:0] OP_OR    = 5'd6;
  localparam logic [4:0] OP_CP    = 5'd7;
  localparam logic [4:0] OP_INC   = 5'd8;
  localparam logic [4:0] OP_DEC   = 5'd9;
  localparam logic [4:0] OP_RLC   = 5'd10;
  localparam logic [4:0] OP_RRC   = 5'd11;
  localparam logic [4:0] OP_RL    = 5'd12;
  localparam logic [4:0] OP_RR    = 5'd13;
  localparam logic [4:0] OP_SLA   = 5'd14;
  localparam logic [4:0] OP_SRA   = 5'd15;
  localparam logic [4:0] OP_SLL   = 5'd16;
  localparam logic [4:0] OP_SRL   = 5'd17;
  localparam logic [4:0] OP_BIT   = 5'd18;
  localparam logic [4:0] OP_RES   = 5'd19;
  localparam logic [4:0] OP_SET   = 5'd20;
  localparam logic [4:0] OP_ADD16 = 5'd21;

  // Flag bit positions in the F register.
  localparam int FLAG_S  = 7;
  localparam int FLAG_Z  = 6;
  localparam int FLAG_H  = 4;
  localparam int FLAG_PV = 2;
  localparam int FLAG_N  = 1;
  localparam int FLAG_C  = 0;

  // Bits 3 and 5 of F always read zero.
  localparam logic [7:0] FLAG_KEEP = 8'hD7;

  // One finished ALU result.
  typedef struct packed {
    logic [15:0] result;
    logic [7:0]  flags;
    logic        write;
  } alu_out_t;

  // Returns 1 when the byte has an even number of set bits.
  function automatic logic parity_even(input logic [7:0] v);
    parity_even = ~(^v);
  endfunction

endpackage

// File: src/z80alu_calc.sv
// Combinational Z80 ALU datapath: result, flags and write enable for one
// operation. Depends on z80alu_pkg.
module z80alu_calc (
  input  logic [4:0]            mode,
  input  logic [15:0]           operand_a,
  input  logic [15:0]           operand_b,
  input  logic [2:0]            bit_index,
  input  logic [7:0]            flags_in,
  output z80alu_pkg::alu_out_t  alu_out
);

  logic [7:0]  a;
  logic [7:0]  b;
  logic [7:0]  fin;
  logic        cin;
  logic        cuse;
  logic [8:0]  add9;
  logic [4:0]  addh;
  logic [8:0]  sub9;
  logic [4:0]  subh;
  logic [16:0] add17;
  logic [12:0] addh16;
  logic [7:0]  r8;
  logic        sc;
  logic [7:0]  bmask;
  logic [7:0]  f;
  logic [15:0] r;
  logic        wr;

  assign a    = operand_a[7:0];
  assign b    = operand_b[7:0];
  assign fin  = flags_in & z80alu_pkg::FLAG_KEEP;
  assign cin  = fin[z80alu_pkg::FLAG_C];
  assign cuse = ((mode == z80alu_pkg::OP_ADC) || (mode == z80alu_pkg::OP_SBC)) ? cin : 1'b0;

  // Shared adders: 8-bit add and subtract with carry, 16-bit add.
  assign add9   = {1'b0, a} + {1'b0, b} + {8'h00, cuse};
  assign addh   = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, cuse};
  assign sub9   = {1'b0, a} - {1'b0, b} - {8'h00, cuse};
  assign subh   = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, cuse};
  assign add17  = {1'b0, operand_a} + {1'b0, operand_b};
  assign addh16 = {1'b0, operand_a[11:0]} + {1'b0, operand_b[11:0]};
  assign bmask  = 8'h01 << bit_index;

  // Operation select and flag generation.
  always_comb begin
    r8 = 8'h00;
    sc = 1'b0;
    f  = fin;
    r  = 16'h0000;
    wr = 1'b1;
    case (mode)
      z80alu_pkg::OP_ADD, z80alu_pkg::OP_ADC: begin
        r8 = add9[7:0];
        f  = 8'h00;
        f[z80alu_pkg::FLAG_C]  = add9[8];
        f[z80alu_pkg::FLAG_H]  = addh[4];
        f[z80alu_pkg::FLAG_PV] = ~(a[7] ^ b[7]) & (a[7] ^ r8[7]);
      end
      z80alu_pkg::OP_SUB, z80alu_pkg::OP_SBC, z80alu_pkg::OP_CP: begin
        r8 = sub9[7:0];
        f  = 8'h00;
        f[z80alu_pkg::FLAG_N]  = 1'b1;
        f[z80alu_pkg::FLAG_C]  = sub9[8];
        f[z80alu_pkg::FLAG_H]  = subh[4];
        f[z80alu_pkg::FLAG_PV] = (a[7] ^ b[7]) & (a[7] ^ r8[7]);
        wr = (mode != z80alu_pkg::OP_CP);
      end
      z80alu_pkg::OP_AND: begin
        r8 = a & b;
        f  = 8'h00;
        f[z80alu_pkg::FLAG_H]  = 1'b1;
        f[z80alu_pkg::FLAG_PV] = z80alu_pkg::parity_even(r8);
      end
      z80alu_pkg::OP_XOR: begin
        r8 = a ^ b;
        f  = 8'h00;
        f[z80alu_pkg::FLAG_PV] = z80alu_pkg::parity_even(r8);
      end
      z80alu_pkg::OP_OR: begin
        r8 = a | b;
        f  = 8'h00;
        f[z80alu_pkg::FLAG_PV] = z80alu_pkg::parity_even(r8);
      end
      z80alu_pkg::OP_INC: begin
        r8 = a + 8'h01;
        f  = 8'h00;
        f[z80alu_pkg::FLAG_C]  = cin;
        f[z80alu_pkg::FLAG_H]  = (a[3:0] == 4'hF);
        f[z80alu_pkg::FLAG_PV] = (a == 8'h7F);
      end
      z80alu_pkg::OP_DEC: begin
        r8 = a - 8'h01;
        f  = 8'h00;
        f[z80alu_pkg::FLAG_C]  = cin;
        f[z80alu_pkg::FLAG_N]  = 1'b1;
        f[z80alu_pkg::FLAG_H]  = (a[3:0] == 4'h0);
        f[z80alu_pkg::FLAG_PV] = (a == 8'h80);
      end
      z80alu_pkg::OP_RLC, z80alu_pkg::OP_RRC, z80alu_pkg::OP_RL, z80alu_pkg::OP_RR,
      z80alu_pkg::OP_SLA, z80alu_pkg::OP_SRA, z80alu_pkg::OP_SLL, z80alu_pkg::OP_SRL: begin
        case (mode)
          z80alu_pkg::OP_RLC: begin r8 = {a[6:0], a[7]}; sc = a[7]; end
          z80alu_pkg::OP_RRC: begin r8 = {a[0], a[7:1]}; sc = a[0]; end
          z80alu_pkg::OP_RL:  begin r8 = {a[6:0], cin};  sc = a[7]; end
          z80alu_pkg::OP_RR:  begin r8 = {cin, a[7:1]};  sc = a[0]; end
          z80alu_pkg::OP_SLA: begin r8 = {a[6:0], 1'b0}; sc = a[7]; end
          z80alu_pkg::OP_SRA: begin r8 = {a[7], a[7:1]}; sc = a[0]; end
          z80alu_pkg::OP_SLL: begin r8 = {a[6:0], 1'b1}; sc = a[7]; end
          default:            begin r8 = {1'b0, a[7:1]}; sc = a[0]; end
        endcase
        f = 8'h00;
        f[z80alu_pkg::FLAG_C]  = sc;
        f[z80alu_pkg::FLAG_PV] = z80alu_pkg::parity_even(r8);
      end
      z80alu_pkg::OP_BIT: begin
        r8 = a;
        f  = 8'h00;
        f[z80alu_pkg::FLAG_S]  = fin[z80alu_pkg::FLAG_S];
        f[z80alu_pkg::FLAG_PV] = fin[z80alu_pkg::FLAG_PV];
        f[z80alu_pkg::FLAG_C]  = fin[z80alu_pkg::FLAG_C];
        f[z80alu_pkg::FLAG_H]  = 1'b1;
        f[z80alu_pkg::FLAG_Z]  = ~(|(a & bmask));
        wr = 1'b0;
      end
      z80alu_pkg::OP_RES: begin
        r8 = a & ~bmask;
      end
      z80alu_pkg::OP_SET: begin
        r8 = a | bmask;
      end
      z80alu_pkg::OP_ADD16: begin
        f = 8'h00;
        f[z80alu_pkg::FLAG_S]  = fin[z80alu_pkg::FLAG_S];
        f[z80alu_pkg::FLAG_Z]  = fin[z80alu_pkg::FLAG_Z];
        f[z80alu_pkg::FLAG_PV] = fin[z80alu_pkg::FLAG_PV];
        f[z80alu_pkg::FLAG_C]  = add17[16];
        f[z80alu_pkg::FLAG_H]  = addh16[12];
      end
      default: begin
        wr = 1'b0;
      end
    endcase

    // Sign and zero come from the byte result for the 8-bit groups that set them.
    case (mode)
      z80alu_pkg::OP_BIT, z80alu_pkg::OP_RES, z80alu_pkg::OP_SET, z80alu_pkg::OP_ADD16: begin
      end
      default: begin
        if (mode <= z80alu_pkg::OP_SRL) begin
          f[z80alu_pkg::FLAG_S] = r8[7];
          f[z80alu_pkg::FLAG_Z] = (r8 == 8'h00);
        end
      end
    endcase

    // Width of the result depends on the group.
    if (mode == z80alu_pkg::OP_ADD16) begin
      r = add17[15:0];
    end else if (mode <= z80alu_pkg::OP_SET) begin
      r = {8'h00, r8};
    end else begin
      r = 16'h0000;
    end
  end

  assign alu_out.result = r;
  assign alu_out.flags  = f & z80alu_pkg::FLAG_KEEP;
  assign alu_out.write  = wr;

endmodule

// File: src/z80_alu_with_flags_core.sv
// An accepted request passes the input register, then the result register; done
// rises with the result held in the result register. Throughput: one
// request every cycle; busy stays low, as the pipeline never holds a request back.
// Reset (rst, synchronous, active high) clears both stage valid bits; payload
// registers are not reset. The receiver cannot stall the done strobe.
// Top level of the Z80 ALU; depends on z80alu_pkg and z80alu_calc.
module z80_alu_with_flags_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  mode,
  input  logic [15:0] operand_a,
  input  logic [15:0] operand_b,
  input  logic [2:0]  bit_index,
  input  logic [7:0]  flags_in,
  output logic        done,
  output logic [15:0] result,
  output logic [7:0]  flags_out,
  output logic        write_result
);

  logic                 in_valid;
  logic [4:0]           in_mode;
  logic [15:0]          in_a;
  logic [15:0]          in_b;
  logic [2:0]           in_bit;
  logic [7:0]           in_flags;
  logic                 accept;
  z80alu_pkg::alu_out_t calc_out;
  z80alu_pkg::alu_out_t out_reg;

  // The pipeline takes a request in every cycle.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Input register stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_mode  <= mode;
      in_a     <= operand_a;
      in_b     <= operand_b;
      in_bit   <= bit_index;
      in_flags <= flags_in;
    end
  end

  // Single-pass ALU datapath.
  z80alu_calc u_calc (
    .mode      (in_mode),
    .operand_a (in_a),
    .operand_b (in_b),
    .bit_index (in_bit),
    .flags_in  (in_flags),
    .alu_out   (calc_out)
  );

  // Result register stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      out_reg <= calc_out;
    end
  end

  assign result       = out_reg.result;
  assign flags_out    = out_reg.flags;
  assign write_result = out_reg.write;

endmodule

// File: src/z80alu_checker.sv
// Port-level checker for the Z80 ALU top level, bound to it below.
// Depends on z80alu_pkg and assert_macros.svh.
`include "assert_macros.svh"

module z80alu_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [4:0]  mode,
  input logic        done,
  input logic [15:0] result,
  input logic [7:0]  flags_out,
  input logic        write_result
);

  logic acc;

  assign acc = start && !busy;

  // Every accepted request yields a done strobe, and done never rises without one.
  `CHK_IMPLY(a_done_latency, clk, rst, $past(acc, 2) && !$past(rst, 1), done)
  `CHK_IMPLY(a_done_cause, clk, rst, done, $past(acc, 2))
  // Reserved flag bits never appear on a result.
  `CHK_IMPLY(a_flag_gaps, clk, rst, done, (flags_out[3] == 1'b0) && (flags_out[5] == 1'b0))
  // Compare and bit test never request a write back.
  `CHK_IMPLY(a_no_write, clk, rst,
    done && (($past(mode, 2) == z80alu_pkg::OP_CP) || ($past(mode, 2) == z80alu_pkg::OP_BIT)),
    !write_result)
  // Only the 16-bit add fills the high byte.
  `CHK_IMPLY(a_high_byte, clk, rst, done && ($past(mode, 2) != z80alu_pkg::OP_ADD16),
    result[15:8] == 8'h00)

endmodule

bind z80_alu_with_flags_core z80alu_checker u_z80alu_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .mode         (mode),
  .done         (done),
  .result       (result),
  .flags_out    (flags_out),
  .write_result (write_result)
);

// File: tb/sv/tb_z80_alu_with_flags_core.sv
// Self-checking testbench for z80_alu_with_flags_core: directed corner requests,
// then random requests with varying sender gaps, each result checked per field.
// Depends on z80alu_pkg and the z80_alu_with_flags_core RTL.
module tb_z80_alu_with_flags_core;
  timeunit 1ns;
  timeprecision 1ps;

  import z80alu_pkg::*;

  localparam int RANDOM_REQS = 1125;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_PRINTED = 100;

  // Flags that a bit test passes through, and the ones a 16-bit add keeps.
  localparam logic [7:0] BIT_PASS_MASK =
    (8'h01 << FLAG_S) | (8'h01 << FLAG_PV) | (8'h01 << FLAG_C);
  localparam logic [7:0] ADD16_KEEP_MASK =
    (8'h01 << FLAG_S) | (8'h01 << FLAG_Z) | (8'h01 << FLAG_PV);

  // One ALU request as the sender presents it.
  typedef struct {
    logic [4:0]  op;
    logic [15:0] a;
    logic [15:0] b;
    logic [2:0]  bidx;
    logic [7:0]  fin;
  } alu_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [4:0]  mode = 5'd0;
  logic [15:0] operand_a = 16'h0000;
  logic [15:0] operand_b = 16'h0000;
  logic [2:0]  bit_index = 3'd0;
  logic [7:0]  flags_in = 8'h00;
  logic        done;
  logic [15:0] result;
  logic [7:0]  flags_out;
  logic        write_result;

  alu_req_t op_queue[$];
  alu_out_t pending_results[$];
  logic     req_taken = 1'b0;
  int       req_total = 0;
  int       req_sent = 0;
  int       err_count = 0;
  int       quiet_cycles = 0;

  z80_alu_with_flags_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .operand_a    (operand_a),
    .operand_b    (operand_b),
    .bit_index    (bit_index),
    .flags_in     (flags_in),
    .done         (done),
    .result       (result),
    .flags_out    (flags_out),
    .write_result (write_result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Sign and zero flags of an 8-bit value.
  function automatic logic [7:0] sign_zero(input logic [7:0] v);
    logic [7:0] f;
    f = 8'h00;
    f[FLAG_S] = v[7];
    f[FLAG_Z] = (v == 8'h00);
    return f;
  endfunction

  // Computes the result, the new F register and the write enable of one request.
  function automatic alu_out_t z80_alu_eval(input alu_req_t rq);
    logic [7:0]  a, b, r8, fk, f;
    logic [8:0]  wide;
    logic [4:0]  nib;
    logic [16:0] sum17;
    logic [12:0] low12;
    logic        cin, cy;
    alu_out_t    o;
    fk = rq.fin & FLAG_KEEP;
    a = rq.a[7:0];
    b = rq.b[7:0];
    cin = fk[FLAG_C];
    f = fk;
    r8 = 8'h00;
    o.result = 16'h0000;
    o.write = 1'b1;
    case (rq.op)
      OP_ADD, OP_ADC: begin
        cy = (rq.op == OP_ADC) ? cin : 1'b0;
        wide = {1'b0, a} + {1'b0, b} + {8'h00, cy};
        nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, cy};
        r8 = wide[7:0];
        f = sign_zero(r8);
        f[FLAG_C] = wide[8];
        f[FLAG_H] = nib[4];
        f[FLAG_PV] = ~(a[7] ^ b[7]) & (a[7] ^ r8[7]);
        o.result = {8'h00, r8};
      end
      OP_SUB, OP_SBC, OP_CP: begin
        // The ninth bit of the difference is the borrow, the fifth of the
        // low-nibble difference the half borrow.
        cy = (rq.op == OP_SBC) ? cin : 1'b0;
        wide = {1'b0, a} - {1'b0, b} - {8'h00, cy};
        nib = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, cy};
        r8 = wide[7:0];
        f = sign_zero(r8);
        f[FLAG_N] = 1'b1;
        f[FLAG_C] = wide[8];
        f[FLAG_H] = nib[4];
        f[FLAG_PV] = (a[7] ^ b[7]) & (a[7] ^ r8[7]);
        o.result = {8'h00, r8};
        o.write = (rq.op != OP_CP);
      end
      OP_AND, OP_XOR, OP_OR: begin
        if (rq.op == OP_AND) begin
          r8 = a & b;
        end else if (rq.op == OP_XOR) begin
          r8 = a ^ b;
        end else begin
          r8 = a | b;
        end
        f = sign_zero(r8);
        f[FLAG_PV] = ~(^r8);
        f[FLAG_H] = (rq.op == OP_AND);
        o.result = {8'h00, r8};
      end
      OP_INC: begin
        r8 = a + 8'h01;
        f = sign_zero(r8);
        f[FLAG_C] = cin;
        f[FLAG_H] = (a[3:0] == 4'hF);
        f[FLAG_PV] = (a == 8'h7F);
        o.result = {8'h00, r8};
      end
      OP_DEC: begin
        r8 = a - 8'h01;
        f = sign_zero(r8);
        f[FLAG_C] = cin;
        f[FLAG_N] = 1'b1;
        f[FLAG_H] = (a[3:0] == 4'h0);
        f[FLAG_PV] = (a == 8'h80);
        o.result = {8'h00, r8};
      end
      OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SLL, OP_SRL: begin
        // Left shifts take carry from bit 7, right shifts from bit 0.
        case (rq.op)
          OP_RLC:  r8 = {a[6:0], a[7]};
          OP_RRC:  r8 = {a[0], a[7:1]};
          OP_RL:   r8 = {a[6:0], cin};
          OP_RR:   r8 = {cin, a[7:1]};
          OP_SLA:  r8 = {a[6:0], 1'b0};
          OP_SRA:  r8 = {a[7], a[7:1]};
          OP_SLL:  r8 = {a[6:0], 1'b1};
          default: r8 = {1'b0, a[7:1]};
        endcase
        if (rq.op == OP_RLC || rq.op == OP_RL || rq.op == OP_SLA || rq.op == OP_SLL) begin
          cy = a[7];
        end else begin
          cy = a[0];
        end
        f = sign_zero(r8);
        f[FLAG_PV] = ~(^r8);
        f[FLAG_C] = cy;
        o.result = {8'h00, r8};
      end
      OP_BIT: begin
        f = fk & BIT_PASS_MASK;
        f[FLAG_H] = 1'b1;
        f[FLAG_Z] = ~a[rq.bidx];
        o.result = {8'h00, a};
        o.write = 1'b0;
      end
      OP_RES, OP_SET: begin
        r8 = a;
        r8[rq.bidx] = (rq.op == OP_SET);
        o.result = {8'h00, r8};
      end
      OP_ADD16: begin
        sum17 = {1'b0, rq.a} + {1'b0, rq.b};
        low12 = {1'b0, rq.a[11:0]} + {1'b0, rq.b[11:0]};
        f = fk & ADD16_KEEP_MASK;
        f[FLAG_C] = sum17[16];
        f[FLAG_H] = low12[12];
        o.result = sum17[15:0];
      end
      default: begin
        // Unused operation codes write nothing and pass the flags through.
        o.write = 1'b0;
      end
    endcase
    o.flags = f & FLAG_KEEP;
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    err_count++;
    if (err_count <= MAX_PRINTED) begin
      $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    end
  endtask

  task automatic queue_req(input logic [4:0] op, input logic [15:0] a,
                           input logic [15:0] b, input logic [2:0] bidx,
                           input logic [7:0] fin);
    alu_req_t rq;
    rq.op = op;
    rq.a = a;
    rq.b = b;
    rq.bidx = bidx;
    rq.fin = fin;
    op_queue.push_back(rq);
  endtask

  // Operand with a boundary byte in the low half about a third of the time.
  function automatic logic [15:0] pick_operand();
    logic [7:0] corner;
    if ($urandom_range(2) != 0) begin
      return 16'($urandom());
    end
    case ($urandom_range(7))
      0:       corner = 8'h00;
      1:       corner = 8'h01;
      2:       corner = 8'h0F;
      3:       corner = 8'h10;
      4:       corner = 8'h7F;
      5:       corner = 8'h80;
      6:       corner = 8'hFE;
      default: corner = 8'hFF;
    endcase
    return {8'($urandom()), corner};
  endfunction

  // Driver: presents the next request at the falling edge, holds it while busy.
  always @(negedge clk) begin : drive_blk
    alu_req_t nxt;
    int idle_pct;
    if (req_sent < req_total / 3) begin
      idle_pct = 18;
    end else if (req_sent < (2 * req_total) / 3) begin
      idle_pct = 56;
    end else begin
      idle_pct = 0;
    end
    if (rst) begin
      start <= 1'b0;
    end else if (start && !req_taken) begin
      start <= 1'b1;
    end else if (op_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
      nxt = op_queue.pop_front();
      mode <= nxt.op;
      operand_a <= nxt.a;
      operand_b <= nxt.b;
      bit_index <= nxt.bidx;
      flags_in <= nxt.fin;
      start <= 1'b1;
    end else begin
      // Idle cycle: the fields carry junk that the block must ignore.
      start <= 1'b0;
      mode <= 5'($urandom());
      operand_a <= 16'($urandom());
      operand_b <= 16'($urandom());
      bit_index <= 3'($urandom());
      flags_in <= 8'($urandom());
    end
  end

  // Monitor: predicts each accepted request, checks each strobed result.
  always @(posedge clk) begin : check_blk
    alu_req_t seen;
    alu_out_t want;
    if (rst) begin
      req_taken <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      req_taken <= start && !busy;
      if (start && !busy) begin
        seen.op = mode;
        seen.a = operand_a;
        seen.b = operand_b;
        seen.bidx = bit_index;
        seen.fin = flags_in;
        pending_results.push_back(z80_alu_eval(seen));
        req_sent++;
      end
      if (done) begin
        if (pending_results.size() == 0) begin
          report_mismatch("done with no request outstanding", 16'h0, 16'h0);
        end else begin
          want = pending_results.pop_front();
          if (result !== want.result) begin
            report_mismatch("result", result, want.result);
          end
          if (flags_out !== want.flags) begin
            report_mismatch("flags_out", {8'h00, flags_out}, {8'h00, want.flags});
          end
          if (write_result !== want.write) begin
            report_mismatch("write_result", {15'h0, write_result}, {15'h0, want.write});
          end
        end
      end
      // Watchdog on cycles where nothing moves in either direction.
      if ((start && !busy) || done) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    // Arithmetic and logic corners: overflow, half carry, carry out, carry in over nine bits.
    queue_req(OP_ADD, 16'h007F, 16'h0001, 3'd0, 8'h00);
    queue_req(OP_ADD, 16'hABFF, 16'h5401, 3'd0, 8'h00);
    queue_req(OP_ADC, 16'h00FF, 16'h0000, 3'd0, 8'hFF);
    queue_req(OP_SUB, 16'h0080, 16'h0001, 3'd0, 8'h00);
    queue_req(OP_SBC, 16'hFF00, 16'h00FF, 3'd0, 8'h01);
    queue_req(OP_AND, 16'h00F0, 16'h000F, 3'd0, 8'h00);
    queue_req(OP_XOR, 16'h00FF, 16'hFF00, 3'd0, 8'hFF);
    queue_req(OP_OR, 16'h0000, 16'h0000, 3'd0, 8'h00);
    queue_req(OP_CP, 16'h0042, 16'h0042, 3'd0, 8'h00);
    // Increment and decrement keep the carry.
    queue_req(OP_INC, 16'h007F, 16'h0000, 3'd0, 8'h01);
    queue_req(OP_INC, 16'hFFFF, 16'h0000, 3'd0, 8'h00);
    queue_req(OP_DEC, 16'h0080, 16'h0000, 3'd0, 8'h01);
    queue_req(OP_DEC, 16'h0000, 16'h0000, 3'd0, 8'h00);
    // Shifts and rotates, each with the carry taken from the operand.
    queue_req(OP_RLC, 16'h0080, 16'h0000, 3'd0, 8'h00);
    queue_req(OP_RRC, 16'h0001, 16'h0000, 3'd0, 8'h00);
    queue_req(OP_RL, 16'h0080, 16'h0000, 3'd0, 8'h01);
    queue_req(OP_RR, 16'h0001, 16'h0000, 3'd0, 8'h01);
    queue_req(OP_SLA, 16'h00FF, 16'h0000, 3'd0, 8'hFF);
    queue_req(OP_SRA, 16'h0081, 16'h0000, 3'd0, 8'h00);
    queue_req(OP_SLL, 16'h0000, 16'h0000, 3'd0, 8'h00);
    queue_req(OP_SRL, 16'h0001, 16'h0000, 3'd0, 8'hFF);
    // Bit test on a clear and a set bit, then bit clear and bit set.
    queue_req(OP_BIT, 16'h007F, 16'h0000, 3'd7, 8'hFF);
    queue_req(OP_BIT, 16'h0001, 16'h0000, 3'd0, 8'h00);
    queue_req(OP_RES, 16'h00FF, 16'h0000, 3'd7, 8'hFF);
    queue_req(OP_SET, 16'h0000, 16'h0000, 3'd0, 8'h00);
    // Sixteen-bit add with carry out and with a half carry from bit 11.
    queue_req(OP_ADD16, 16'hFFFF, 16'h0001, 3'd0, 8'hFF);
    queue_req(OP_ADD16, 16'h0FFF, 16'h0001, 3'd0, 8'h00);
    // Unused operation code.
    queue_req(5'd31, 16'hFFFF, 16'hFFFF, 3'd7, 8'hFF);

    for (int i = 0; i < RANDOM_REQS; i++) begin
      queue_req(($urandom_range(15) == 0) ? 5'($urandom_range(31, 22))
                                          : 5'($urandom_range(21)),
                pick_operand(), pick_operand(), 3'($urandom()), 8'($urandom()));
    end
    req_total = op_queue.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (req_sent < req_total) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
